// ----- rtl/sts_pkg.sv -----
// Shared types and codes for the sorted table ternary search block.
package sts_pkg;

  // request command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam int CMD_W      = 1;
  localparam int INDEX_W    = 10;
  localparam int DATA_W     = 32;
  localparam int LENGTH_W   = 11;
  localparam int POSITION_W = 10;

  // outcome of one key/entry compare
  typedef struct packed {
    logic eq;
    logic lt;  // key below entry
  } cmp_t;

endpackage

// ----- rtl/sts_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/sts_third.sv -----
// Divide-by-three unit: reciprocal multiply, exact for every value of the input width.
module sts_third #(
  parameter int W = 11
) (
  input  logic [W-1:0] size,
  output logic [W-1:0] third
);

  localparam int SH = W + 2;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'd2) / 64'd3;
  localparam logic [SH-1:0] RECIP_V = RECIP[SH-1:0];

  logic [W+SH-1:0] prod;

  assign prod  = {{SH{1'b0}}, size} * {{W{1'b0}}, RECIP_V};
  assign third = prod[W+SH-1:SH];

endmodule

// ----- rtl/sts_cmp.sv -----
// Shared signed comparator between the search key and a table entry.
module sts_cmp (
  input  logic signed [sts_pkg::DATA_W-1:0] key,
  input  logic signed [sts_pkg::DATA_W-1:0] entry,
  output sts_pkg::cmp_t                     res
);

  always_comb begin
    res.eq = (key == entry);
    res.lt = (key < entry);
  end

endmodule

// ----- rtl/sorted_table_ternary_search.sv -----
// Top level of the sorted table ternary search block: sequencer, table and shared units.
//
// Usage
//   Input channel (in_valid / in_stall) carries requests. cmd write stores
//   in_element at in_index and gives no result; an index at or beyond
//   TABLE_DEPTH is dropped. cmd search looks for in_key in entries
//   0 .. table_length-1 (clamped to TABLE_DEPTH), which must be ascending.
//   Result channel (out_valid / out_stall) gives one found/position pair per
//   search; position is zero when nothing matched.
//   cfg_wr_en / cfg_wr_data set table_length; write it only while idle.
// Sequencing
//   A search runs rounds of steps (divide range by three, probe address,
//   compare first probe, compare second probe) through one RAM read port
//   and one comparator; the round count is about log3(table_length)+1.
//   in_stall is high from the search request until its result is
//   registered.
// Reset and stalls
//   Reset clears the sequencer, the output valid flag and table_length; the
//   table itself holds no reset value. A finished result waits in the output
//   register while out_stall is high, and new requests are taken meanwhile.
module sorted_table_ternary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sts_pkg::CMD_W-1:0]           in_cmd,
  input  logic [sts_pkg::INDEX_W-1:0]         in_index,
  input  logic signed [sts_pkg::DATA_W-1:0]   in_element,
  input  logic signed [sts_pkg::DATA_W-1:0]   in_key,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [sts_pkg::POSITION_W-1:0]      out_position,
  input  logic                                cfg_wr_en,
  input  logic [sts_pkg::LENGTH_W-1:0]        cfg_wr_data
);

  // AW indexes the table, LW holds any range bound including TABLE_DEPTH
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int RAM_DEPTH = (TABLE_DEPTH > 1) ? TABLE_DEPTH : 2;
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD1,
    S_RD2,
    S_CMP2,
    S_DONE
  } state_t;

  state_t state_r;

  logic [sts_pkg::LENGTH_W-1:0] table_length_r;
  logic [LW-1:0]                lo_r, end_r, third_r, p1_r, p2_r;
  logic signed [sts_pkg::DATA_W-1:0] key_r;
  logic                         lt1_r;
  logic                         res_found_r;
  logic [LW-1:0]                res_pos_r;
  logic                         out_valid_r, out_found_r;
  logic [sts_pkg::POSITION_W-1:0] out_position_r;

  logic          in_accept;
  logic [31:0]   len32;
  logic [LW-1:0] len_clamped;
  logic [LW-1:0] third_w, p1_w, p2_w;
  logic [LW+sts_pkg::POSITION_W-1:0] pos_ext;
  logic [AW+sts_pkg::INDEX_W-1:0]    idx_ext;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic          ram_wr_en;
  logic signed [sts_pkg::DATA_W-1:0] ram_rd_data;
  sts_pkg::cmp_t cmp;
  logic          out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // effective length, clamped to the table size
  assign len32       = {21'b0, table_length_r};
  assign len_clamped = (len32 > DEPTH32) ? LW'(TABLE_DEPTH) : len32[LW-1:0];

  // write side: drop indices beyond the table
  assign idx_ext     = {{AW{1'b0}}, in_index};
  assign ram_wr_addr = idx_ext[AW-1:0];
  assign ram_wr_en   = in_accept && (in_cmd == sts_pkg::CMD_WRITE) &&
                       ({22'b0, in_index} < DEPTH32);

  // probe positions one third in from each end of [lo, end)
  assign p1_w = lo_r + third_r;
  assign p2_w = end_r - LW'(1) - third_r;
  assign ram_rd_addr = (state_r == S_RD1) ? p1_w[AW-1:0] : p2_r[AW-1:0];

  assign pos_ext = {{sts_pkg::POSITION_W{1'b0}}, res_pos_r};

  sts_ram #(
    .WIDTH (sts_pkg::DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_element),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  sts_third #(
    .W (LW)
  ) u_third (
    .size  (end_r - lo_r),
    .third (third_w)
  );

  sts_cmp u_cmp (
    .key   (key_r),
    .entry (ram_rd_data),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (cfg_wr_en) begin
      table_length_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // S_DONE reloads the slot itself when it is taken
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept && (in_cmd == sts_pkg::CMD_SEARCH)) begin
            key_r   <= in_key;
            lo_r    <= '0;
            end_r   <= len_clamped;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (lo_r >= end_r) begin
            // empty range: not found
            res_found_r <= 1'b0;
            res_pos_r   <= '0;
            state_r     <= S_DONE;
          end else begin
            third_r <= third_w;
            state_r <= S_RD1;
          end
        end
        S_RD1: begin
          p1_r    <= p1_w;
          p2_r    <= p2_w;
          state_r <= S_RD2;
        end
        S_RD2: begin
          // read data holds the first probe
          if (cmp.eq) begin
            res_found_r <= 1'b1;
            res_pos_r   <= p1_r;
            state_r     <= S_DONE;
          end else begin
            lt1_r   <= cmp.lt;
            state_r <= S_CMP2;
          end
        end
        S_CMP2: begin
          // read data holds the second probe
          if (cmp.eq) begin
            res_found_r <= 1'b1;
            res_pos_r   <= p2_r;
            state_r     <= S_DONE;
          end else begin
            if (lt1_r) begin
              end_r <= p1_r;
            end else if (cmp.lt) begin
              lo_r  <= p1_r + LW'(1);
              end_r <= p2_r;
            end else begin
              lo_r  <= p2_r + LW'(1);
            end
            state_r <= S_DIV;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_found_r    <= res_found_r;
            out_position_r <= pos_ext[sts_pkg::POSITION_W-1:0];
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  // a miss always reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_position_r == '0)
    else $error("miss with non-zero position");

  // the search range never inverts and never leaves the table
  a_range_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> lo_r <= end_r && {{(32-LW){1'b0}}, end_r} <= DEPTH32)
    else $error("search range out of bounds");

  // a search request starts the sequencer on the next cycle
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_cmd == sts_pkg::CMD_SEARCH |=> state_r == S_DIV)
    else $error("search request not started");

  // the result register is only loaded when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && out_stall |=> state_r == S_DONE)
    else $error("result dropped while receiver stalled");

endmodule
